>>> rtl/thadc_pkg.sv
// ----------------------------------------------------------------------------
// thadc_pkg
// Shared types, curve tables and constants for the thermistor ADC to
// temperature converter.
// ----------------------------------------------------------------------------
package thadc_pkg;

    localparam int ADC_BITS    = 12;
    localparam int CURVE_POINTS = 19;
    localparam int SEG_COUNT   = CURVE_POINTS - 1;
    localparam int SEG_W       = $clog2(SEG_COUNT);
    localparam int A_W         = 6;
    localparam int TEMP_W      = 8;
    localparam int NUM_W       = ADC_BITS + 1;
    localparam int DIV_STEPS   = ADC_BITS;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    localparam logic [ADC_BITS-1:0] MARGIN_RESET = ADC_BITS'(500);
    localparam logic [ADC_BITS-1:0] LAST_RESET   = ADC_BITS'(3645);

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -8'sd30;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 8'sd80;

    // adc code at -20 C .. 70 C in 5 degree steps
    localparam logic [ADC_BITS-1:0] CURVE_ADC [CURVE_POINTS] = '{
        3795, 3691, 3561, 3405, 3222, 3014, 2787, 2544, 2296, 2048,
        1808, 1583, 1375, 1187, 1021, 875, 748, 640, 547
    };

    // slope magnitude per segment, slope itself is negative
    localparam logic [A_W-1:0] SLOPE_MAG [SEG_COUNT] = '{
        20, 26, 31, 36, 41, 45, 48, 49, 49, 48,
        45, 41, 37, 33, 29, 25, 21, 18
    };

    // intercept per segment
    localparam logic [ADC_BITS-1:0] INTERCEPT [SEG_COUNT] = '{
        3379, 3301, 3249, 3222, 3222, 3241, 3273, 3288, 3288, 3248,
        3158, 3039, 2879, 2681, 2481, 2272, 2044, 1849
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEG,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic seg;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_sts;

    // first (coldest) segment holding v
    function automatic logic [SEG_W-1:0] seg_find(input logic [ADC_BITS-1:0] v);
        logic [SEG_W-1:0] seg;
        seg = '0;
        for (int i = SEG_COUNT - 1; i >= 0; i--) begin
            if (v >= CURVE_ADC[i+1] && v <= CURVE_ADC[i]) begin
                seg = SEG_W'(i);
            end
        end
        return seg;
    endfunction

endpackage

>>> rtl/thermistor_adc_to_temperature.sv
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature
// Battery thermistor sample to degrees Celsius: spike rejection against the
// last sample, then a 19-point piecewise linear curve with saturation.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+----------------------------
//   in       | input     | i_in_valid/o_in_stall  | i_sample[11:0]
//   out      | output    | o_out_valid/i_out_stall| o_temperature, o_spike_replaced
//   cfg      | input     | i_cfg_valid/o_cfg_ready| i_cfg_data (spike margin)
//
// a beat passes through spike check, segment select, ADC_BITS restoring
// divide steps and output load.
// next beat is taken the cycle after the result enters the output register.
// a stalled result holds the block in its last step until taken.
// reset is synchronous: margin 500, last sample 3645, no result pending.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature import thadc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [ADC_BITS-1:0]      i_sample,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [TEMP_W-1:0] o_temperature,
    output logic                     o_spike_replaced,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [ADC_BITS-1:0]      i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    thadc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    thadc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_sample         (i_sample),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_temperature    (o_temperature),
        .o_spike_replaced (o_spike_replaced)
    );

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_temperature >= TEMP_MIN && o_temperature <= TEMP_MAX))
        else $error("temperature out of saturation range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("beat accepted while previous one in flight");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a beat in flight");

endmodule

>>> rtl/thadc_ctrl.sv
// ----------------------------------------------------------------------------
// thadc_ctrl
// Sequencer: takes one beat, steps the datapath through segment select,
// the divide iterations and the output load.
// ----------------------------------------------------------------------------
module thadc_ctrl import thadc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEG;
                end
            end
            ST_SEG: begin
                o_cmd.seg = 1'b1;
                n_cnt     = '0;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/thadc_dp.sv
// ----------------------------------------------------------------------------
// thadc_dp
// Datapath: spike check, last sample and margin registers, segment select,
// restoring divider and the saturating output register.
// ----------------------------------------------------------------------------
module thadc_dp import thadc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic [ADC_BITS-1:0]      i_cfg_data,
    input  logic [ADC_BITS-1:0]      i_sample,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic signed [TEMP_W-1:0] o_temperature,
    output logic                     o_spike_replaced
);

    logic [ADC_BITS-1:0]      r_margin;
    logic [ADC_BITS-1:0]      r_last;
    logic [ADC_BITS-1:0]      r_val;
    logic                     r_repl;
    logic                     r_neg;
    logic [ADC_BITS-1:0]      r_dvd;
    logic [A_W-1:0]           r_rem;
    logic [A_W-1:0]           r_dvsr;
    logic                     r_out_valid;
    logic signed [TEMP_W-1:0] r_temp;
    logic                     r_out_repl;

    logic [ADC_BITS:0]        lim;
    logic                     spike;
    logic [ADC_BITS-1:0]      v;
    logic [ADC_BITS-1:0]      v_clamp;
    logic [SEG_W-1:0]         seg;
    logic signed [NUM_W-1:0]  num;
    logic [ADC_BITS-1:0]      num_mag;
    logic [A_W:0]             rem_sh;
    logic [A_W:0]             trial;
    logic                     qbit;
    logic signed [NUM_W-1:0]  q_s;
    logic signed [TEMP_W-1:0] temp_sat;

    // spike check and clamp
    always_comb begin
        lim   = {1'b0, r_last} + {1'b0, r_margin};
        spike = {1'b0, i_sample} > lim;
        v     = spike ? r_last : i_sample;
        if (v > CURVE_ADC[0]) begin
            v_clamp = CURVE_ADC[0];
        end else if (v < CURVE_ADC[CURVE_POINTS-1]) begin
            v_clamp = CURVE_ADC[CURVE_POINTS-1];
        end else begin
            v_clamp = v;
        end
    end

    // numerator v - b
    always_comb begin
        seg     = seg_find(r_val);
        num     = $signed({1'b0, r_val}) - $signed({1'b0, INTERCEPT[seg]});
        num_mag = num[NUM_W-1] ? ADC_BITS'(-num) : num[ADC_BITS-1:0];
    end

    // one quotient bit per step
    always_comb begin
        rem_sh = {r_rem, r_dvd[ADC_BITS-1]};
        trial  = rem_sh - {1'b0, r_dvsr};
        qbit   = (rem_sh >= {1'b0, r_dvsr});
    end

    // sign and saturation, slope is negative
    always_comb begin
        q_s = r_neg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});
        if (q_s < NUM_W'(TEMP_MIN)) begin
            temp_sat = TEMP_MIN;
        end else if (q_s > NUM_W'(TEMP_MAX)) begin
            temp_sat = TEMP_MAX;
        end else begin
            temp_sat = q_s[TEMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_RESET;
            r_last   <= LAST_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_margin <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_last <= v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val  <= v_clamp;
            r_repl <= spike;
        end
        if (i_cmd.seg) begin
            r_neg  <= ~num[NUM_W-1];
            r_dvd  <= num_mag;
            r_rem  <= '0;
            r_dvsr <= SLOPE_MAG[seg];
        end
        if (i_cmd.step) begin
            r_rem <= qbit ? trial[A_W-1:0] : rem_sh[A_W-1:0];
            r_dvd <= {r_dvd[ADC_BITS-2:0], qbit};
        end
        if (i_cmd.finish) begin
            r_temp     <= temp_sat;
            r_out_repl <= r_repl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_busy   = r_out_valid && i_out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_temperature    = r_temp;
    assign o_spike_replaced = r_out_repl;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for thermistor_adc_to_temperature. Sample beats go in
// bursts with random gaps while the result side stalls on its own pattern.
// Every accepted sample is run through a local spike filter and curve
// interpolation, and each result beat is checked field by field against it.
// The spike margin is rewritten between phases, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
    import thadc_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 162;
    localparam int CURVE_N      = 19;
    localparam int ADC_MAX      = (1 << ADC_BITS) - 1;

    localparam int CURVE_CODES [CURVE_N] = '{
        3795, 3691, 3561, 3405, 3222, 3014, 2787, 2544, 2296, 2048,
        1808, 1583, 1375, 1187, 1021, 875, 748, 640, 547
    };

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     spike_replaced;
    } t_reading;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [ADC_BITS-1:0]      i_sample = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [TEMP_W-1:0] o_temperature;
    logic                     o_spike_replaced;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [ADC_BITS-1:0]      i_cfg_data = '0;

    logic [ADC_BITS-1:0] sample_backlog [$];
    t_reading            expected_readings [$];
    logic [ADC_BITS-1:0] spike_margin_now = MARGIN_RESET;
    logic [ADC_BITS-1:0] last_accepted = LAST_RESET;
    int                  gen_last = LAST_RESET;
    int                  fail_count = 0;
    int                  cycle_count = 0;
    int                  burst_left = 1;
    int                  gap_left = 0;
    int                  stall_run = 0;
    logic                stall_mode = 1'b0;

    thermistor_adc_to_temperature i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_temperature    (o_temperature),
        .o_spike_replaced (o_spike_replaced),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // spike filter then piecewise linear curve, truncating divisions
    function automatic t_reading predict_reading(input logic [ADC_BITS-1:0] s);
        t_reading r;
        int       v;
        int       t_hi;
        int       t_lo;
        int       slope;
        int       icept;
        int       deg;
        logic     found;
        r.spike_replaced = 1'b0;
        v = s;
        if (v > int'(last_accepted) + int'(spike_margin_now)) begin
            v = last_accepted;
            r.spike_replaced = 1'b1;
        end
        last_accepted = ADC_BITS'(v);
        if (v > CURVE_CODES[0]) v = CURVE_CODES[0];
        if (v < CURVE_CODES[CURVE_N-1]) v = CURVE_CODES[CURVE_N-1];
        deg = 0;
        found = 1'b0;
        for (int i = 0; i < CURVE_N - 1; i++) begin
            if (!found && v >= CURVE_CODES[i+1] && v <= CURVE_CODES[i]) begin
                found = 1'b1;
                t_hi  = -20 + 5 * i;
                t_lo  = t_hi + 5;
                slope = (CURVE_CODES[i] - CURVE_CODES[i+1]) / (t_hi - t_lo);
                icept = (t_hi * CURVE_CODES[i+1] - t_lo * CURVE_CODES[i]) / (t_hi - t_lo);
                deg   = (v - icept) / slope;
            end
        end
        if (deg < -30) deg = -30;
        if (deg > 80) deg = 80;
        r.temperature = TEMP_W'(deg);
        return r;
    endfunction

    function automatic void push_sample(input int s);
        if (s < 0) s = 0;
        if (s > ADC_MAX) s = ADC_MAX;
        sample_backlog.push_back(ADC_BITS'(s));
        if (s <= gen_last + int'(spike_margin_now)) gen_last = s;
    endfunction

    // mostly slow drift with some noise, boundary rises and spikes
    task automatic queue_phase(input int count);
        int r;
        int m;
        m = spike_margin_now;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                push_sample(gen_last + int'($urandom_range(0, 400)) - 200);
            end else if (r < 72) begin
                push_sample($urandom_range(0, ADC_MAX));
            end else if (r < 88) begin
                push_sample(gen_last + m + int'($urandom_range(0, 2)) - 1);
            end else begin
                push_sample(gen_last + m + int'($urandom_range(1, ADC_MAX)));
            end
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (sample_backlog.size() != 0 || i_in_valid || expected_readings.size() != 0);
    endtask

    task automatic write_margin(input logic [ADC_BITS-1:0] m);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        spike_margin_now = m;
        i_cfg_valid <= 1'b0;
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_readings.push_back(predict_reading(i_sample));
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (sample_backlog.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_sample   <= sample_backlog.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result side stall runs
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = ($urandom_range(0, 2) == 0);
            stall_run  = stall_mode ? $urandom_range(1, 40) : $urandom_range(1, 60);
        end
        stall_run--;
        i_out_stall <= stall_mode && ($urandom_range(0, 3) != 0);
    end

    // result monitor
    always @(posedge i_clk) begin : monitor
        t_reading want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_readings.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                want = expected_readings.pop_front();
                if (o_temperature !== want.temperature) begin
                    $error("temperature: expected %0d, got %0d",
                           want.temperature, o_temperature);
                    fail_count++;
                end
                if (o_spike_replaced !== want.spike_replaced) begin
                    $error("spike_replaced: expected %0d, got %0d",
                           want.spike_replaced, o_spike_replaced);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        int directed [] = '{4095, 0, 500, 1001, 1000, 1500, 2001, 2000, 2500, 3000,
                            3500, 3795, 3796, 3691, 3561, 2048, 1808, 1375, 547,
                            546, 640, 4095, 3000};
        int margins [] = '{0, 4095, 1, 100, 4094, 2000, 500, 0};
        margins[5] = $urandom_range(0, ADC_MAX);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset margin: ends of the curve, shared points, rise at the margin
        foreach (directed[k]) push_sample(directed[k]);
        wait_idle();

        foreach (margins[k]) begin
            write_margin(ADC_BITS'(margins[k]));
            queue_phase(PHASE_ITEMS);
            wait_idle();
        end

        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && expected_readings.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/thadc_pkg.sv
rtl/thadc_ctrl.sv
rtl/thadc_dp.sv
rtl/thermistor_adc_to_temperature.sv
test/tb_top.sv
